// ===== rtl/core/dogkp_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dogkp_pkg
// Shared types, widths and codes of the DoG extremum keypoint detector.
// ============================================================================
package dogkp_pkg;

    // Sizing of the line store and the sample path.
    localparam int MAX_WIDTH   = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);

    // Fixed field widths.
    localparam int FW_BITS   = 11;
    localparam int FH_BITS   = 12;
    localparam int CONT_BITS = 15;
    localparam int CURV_BITS = 16;
    localparam int CX_BITS   = 10;
    localparam int CY_BITS   = 12;
    localparam int IDX_BITS  = 8;
    localparam int CFG_BITS  = 16;

    // Arithmetic widths of the edge test.
    localparam int DIFF_BITS = SAMPLE_BITS + 2;
    localparam int SUM_BITS  = DIFF_BITS + 1;
    localparam int PROD_BITS = 2 * DIFF_BITS;
    localparam int DET_BITS  = PROD_BITS + 6;
    localparam int LHS_BITS  = 2 * SUM_BITS + 12;
    localparam int RHS_BITS  = CURV_BITS + DET_BITS - 1;
    localparam int CMP_BITS  = (LHS_BITS > RHS_BITS) ? LHS_BITS : RHS_BITS;

    // Register indexes.
    localparam logic [IDX_BITS-1:0] REG_FRAME_WIDTH     = 8'd0;
    localparam logic [IDX_BITS-1:0] REG_FRAME_HEIGHT    = 8'd1;
    localparam logic [IDX_BITS-1:0] REG_CONTRAST_LIMIT  = 8'd2;
    localparam logic [IDX_BITS-1:0] REG_CURVATURE_LIMIT = 8'd3;

    // Register reset values.
    localparam logic [FW_BITS-1:0]   RST_FRAME_WIDTH     = 11'd640;
    localparam logic [FH_BITS-1:0]   RST_FRAME_HEIGHT    = 12'd480;
    localparam logic [CONT_BITS-1:0] RST_CONTRAST_LIMIT  = 15'd492;
    localparam logic [CURV_BITS-1:0] RST_CURVATURE_LIMIT = 16'd3098;

    // Verdict codes.
    localparam logic [1:0] VERDICT_NONE     = 2'd0;
    localparam logic [1:0] VERDICT_KEYPOINT = 2'd1;
    localparam logic [1:0] VERDICT_LOW      = 2'd2;
    localparam logic [1:0] VERDICT_EDGE     = 2'd3;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    // One position of three scales: index 0 below, 1 middle, 2 above.
    typedef sample_t [2:0] triple_t;

    typedef struct packed {
        sample_t sample_below;
        sample_t sample_mid;
        sample_t sample_above;
        logic    start_of_frame;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         verdict;
        logic               is_maximum;
        logic [CX_BITS-1:0] centre_x;
        logic [CY_BITS-1:0] centre_y;
        logic               frame_done;
    } out_item_t;

    // Step strobes from the sequencer to the evaluation datapath.
    typedef struct packed {
        logic shift;
        logic calc;
        logic mul;
        logic sub;
        logic fmul;
        logic border_ok;
    } eval_ctl_t;

endpackage

// ===== rtl/core/dogkp_ram.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dogkp_ram
// Simple dual-port synchronous RAM with one write port and a registered read.
// ============================================================================
module dogkp_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 96
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/dogkp_eval.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dogkp_eval
// 3x3x3 window, 26-neighbour extremum test, contrast test and the
// cross-multiplied Hessian edge test, one step per strobe.
// ============================================================================
module dogkp_eval (
    input  logic                                clk,
    input  logic                                rst_n,
    input  dogkp_pkg::eval_ctl_t                ctl,
    input  dogkp_pkg::triple_t                  col_line0,
    input  dogkp_pkg::triple_t                  col_line1,
    input  dogkp_pkg::triple_t                  col_new,
    input  logic [dogkp_pkg::CONT_BITS-1:0]     contrast_limit,
    input  logic [dogkp_pkg::CURV_BITS-1:0]     curvature_limit,
    output logic [1:0]                          verdict,
    output logic                                is_maximum
);

    localparam int SB = dogkp_pkg::SAMPLE_BITS;
    localparam int DB = dogkp_pkg::DIFF_BITS;
    localparam int UB = dogkp_pkg::SUM_BITS;
    localparam int PB = dogkp_pkg::PROD_BITS;
    localparam int EB = dogkp_pkg::DET_BITS;
    localparam int CB = dogkp_pkg::CMP_BITS;

    dogkp_pkg::triple_t win_reg [3][3];

    logic                 cand_reg;
    logic                 ismax_reg;
    logic                 low_reg;
    logic signed [DB-1:0] dxx_reg;
    logic signed [DB-1:0] dyy_reg;
    logic signed [DB-1:0] e_reg;
    logic signed [PB-1:0] p_reg;
    logic signed [PB-1:0] q_reg;
    logic [2*UB-1:0]      s2_reg;
    logic                 bad_reg;
    logic signed [EB-1:0] d_reg;
    logic                 dpos_reg;
    logic [CB-1:0]        lhs_reg;
    logic [CB-1:0]        rhs_reg;

    logic                 gt_next;
    logic                 lt_next;
    logic signed [SB-1:0] ctr;
    logic [SB:0]          ctr_mag;
    logic signed [DB-1:0] dxx_next;
    logic signed [DB-1:0] dyy_next;
    logic signed [DB-1:0] e_next;
    logic signed [UB-1:0] sum_next;
    logic signed [EB-1:0] d_next;
    logic                 reject;

    // Window shift: each line moves one column left, new column enters right.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (ctl.shift)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= col_line0;
            win_reg[1][2] <= col_line1;
            win_reg[2][2] <= col_new;
        end
    end

    // Strict extremum test against all 26 neighbours.
    always_comb
    begin
        ctr     = $signed(win_reg[1][1][1]);
        gt_next = 1'b1;
        lt_next = 1'b1;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (!(r == 1 && c == 1 && k == 1))
                    begin
                        if (!(ctr > $signed(win_reg[r][c][k])))
                        begin
                            gt_next = 1'b0;
                        end
                        if (!(ctr < $signed(win_reg[r][c][k])))
                        begin
                            lt_next = 1'b0;
                        end
                    end
                end
            end
        end
    end

    // Centre magnitude, second and cross differences of the middle scale, trace and determinant.
    always_comb
    begin
        ctr_mag  = ctr[SB-1] ? (SB+1)'(-((SB+1)'(ctr))) : (SB+1)'(ctr);
        dxx_next = DB'($signed(win_reg[0][1][1])) + DB'($signed(win_reg[2][1][1]))
                 - (DB'(ctr) <<< 1);
        dyy_next = DB'($signed(win_reg[1][0][1])) + DB'($signed(win_reg[1][2][1]))
                 - (DB'(ctr) <<< 1);
        e_next   = DB'($signed(win_reg[0][0][1])) + DB'($signed(win_reg[2][2][1]))
                 - DB'($signed(win_reg[2][0][1])) - DB'($signed(win_reg[0][2][1]));
        sum_next = UB'(dxx_reg) + UB'(dyy_reg);
        d_next   = (EB'(p_reg) <<< 4) - EB'(q_reg);
    end

    // Edge-test pipeline, one stage per strobe.
    always_ff @(posedge clk)
    begin
        if (ctl.calc)
        begin
            cand_reg  <= ctl.border_ok && (gt_next || lt_next);
            ismax_reg <= gt_next;
            low_reg   <= ctr_mag < (SB+1)'(contrast_limit);
            dxx_reg   <= dxx_next;
            dyy_reg   <= dyy_next;
            e_reg     <= e_next;
        end
        if (ctl.mul)
        begin
            p_reg   <= PB'(dxx_reg * dyy_reg);
            q_reg   <= PB'(e_reg * e_reg);
            s2_reg  <= (2*UB)'(sum_next * sum_next);
            bad_reg <= (dxx_reg == '0) || (dyy_reg == '0) || (dxx_reg[DB-1] != dyy_reg[DB-1]);
        end
        if (ctl.sub)
        begin
            d_reg    <= d_next;
            dpos_reg <= !d_next[EB-1] && (d_next != '0);
            lhs_reg  <= CB'(s2_reg) << 12;
        end
        if (ctl.fmul)
        begin
            rhs_reg <= CB'(curvature_limit * d_reg[EB-2:0]);
        end
    end

    // Final verdict from the held stage results.
    always_comb
    begin
        reject = bad_reg || !dpos_reg || (lhs_reg > rhs_reg);
        if (!cand_reg)
        begin
            verdict = dogkp_pkg::VERDICT_NONE;
        end
        else if (low_reg)
        begin
            verdict = dogkp_pkg::VERDICT_LOW;
        end
        else if (reject)
        begin
            verdict = dogkp_pkg::VERDICT_EDGE;
        end
        else
        begin
            verdict = dogkp_pkg::VERDICT_KEYPOINT;
        end
        is_maximum = cand_reg && ismax_reg;
    end

endmodule

// ===== rtl/core/dog_extremum_keypoint_detector.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dog_extremum_keypoint_detector
// Raster-order DoG extremum detector with contrast and edge rejection.
// ============================================================================
// Usage:
//   The pix channel takes one pixel position per item: the co-located samples
//   of three adjacent DoG scales plus a start-of-frame flag. The res channel
//   gives exactly one result item per input item, in order, for the centre one
//   line up and one column left of the arriving pixel.
//   The cfg channel writes frame size and the two limits; cfg_ready is always
//   high, and writes belong in idle periods only.
//   Each item passes from acceptance to a loaded result register through
//   window shift and line-store write-back, compare, multiply, subtract,
//   curvature multiply and result load, in that order; the line store is
//   read at the accepting edge. The sequencer holds one item at a time and
//   takes no new one until the result load is done; the line-store
//   read-modify-write and the multiplier chain set this limit.
//   After reset the line store is cleared, one entry per cycle, across all
//   MAX_WIDTH (1024) entries; pix_stall stays high during that pass.
//   When the receiver stalls, the result item holds in the output register;
//   the next item is still accepted and processed, and waits in its last step
//   until the register is free.
// ============================================================================
module dog_extremum_keypoint_detector (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               pix_valid,
    output logic                               pix_stall,
    input  dogkp_pkg::in_item_t                pix_data,
    output logic                               res_valid,
    input  logic                               res_stall,
    output dogkp_pkg::out_item_t               res_data,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [dogkp_pkg::IDX_BITS-1:0]     cfg_index,
    input  logic [dogkp_pkg::CFG_BITS-1:0]     cfg_data
);

    localparam int XB = dogkp_pkg::COL_BITS;
    localparam int WB = dogkp_pkg::FW_BITS;
    localparam int HB = dogkp_pkg::FH_BITS;
    localparam int TB = 3 * dogkp_pkg::SAMPLE_BITS;

    typedef enum logic [7:0] {
        ST_CLR  = 8'b0000_0001,
        ST_IDLE = 8'b0000_0010,
        ST_WIN  = 8'b0000_0100,
        ST_CALC = 8'b0000_1000,
        ST_MUL  = 8'b0001_0000,
        ST_SUB  = 8'b0010_0000,
        ST_FMUL = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    logic [WB-1:0]                  fw_reg;
    logic [HB-1:0]                  fh_reg;
    logic [dogkp_pkg::CONT_BITS-1:0] cl_reg;
    logic [dogkp_pkg::CURV_BITS-1:0] kl_reg;

    logic [XB-1:0] col_reg, col_next;
    logic [HB-1:0] line_reg, line_next;
    logic [XB-1:0] clr_reg;
    logic [XB-1:0] x_reg;
    logic [HB-1:0] y_reg;
    logic          border_reg;
    logic          done_reg;
    dogkp_pkg::triple_t s_reg;

    logic          res_valid_reg;
    dogkp_pkg::out_item_t res_reg;

    logic          accept;
    logic          out_free;
    logic [XB-1:0] x_cur;
    logic [HB-1:0] y_cur;
    logic [WB-1:0] fw_clamp;
    logic [HB-1:0] fh_clamp;

    logic              ram_we;
    logic [XB-1:0]     ram_waddr;
    logic [2*TB-1:0]   ram_wdata;
    logic [2*TB-1:0]   ram_rdata;
    dogkp_pkg::triple_t rd_line0;
    dogkp_pkg::triple_t rd_line1;

    dogkp_pkg::eval_ctl_t ctl;
    logic [1:0]           ev_verdict;
    logic                 ev_is_max;

    assign pix_stall = (state_reg != ST_IDLE);
    assign accept    = pix_valid && !pix_stall;
    assign res_valid = res_valid_reg;
    assign res_data  = res_reg;
    assign cfg_ready = 1'b1;
    assign out_free  = !res_valid_reg || !res_stall;

    // Position of the arriving pixel.
    assign x_cur = pix_data.start_of_frame ? '0 : col_reg;
    assign y_cur = pix_data.start_of_frame ? '0 : line_reg;

    // Raster position advance with wrap at the current frame size.
    always_comb
    begin
        if ((WB+1)'(x_cur) + 1'b1 >= (WB+1)'(fw_reg))
        begin
            col_next  = '0;
            line_next = ((HB+1)'(y_cur) + 1'b1 >= (HB+1)'(fh_reg)) ? '0 : y_cur + 1'b1;
        end
        else
        begin
            col_next  = x_cur + 1'b1;
            line_next = y_cur;
        end
    end

    // Clamped register values.
    always_comb
    begin
        fw_clamp = cfg_data[WB-1:0];
        if (fw_clamp < WB'(3))
        begin
            fw_clamp = WB'(3);
        end
        if (fw_clamp > WB'(dogkp_pkg::MAX_WIDTH))
        begin
            fw_clamp = WB'(dogkp_pkg::MAX_WIDTH);
        end
        fh_clamp = cfg_data[HB-1:0];
        if (fh_clamp < HB'(3))
        begin
            fh_clamp = HB'(3);
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= dogkp_pkg::RST_FRAME_WIDTH;
            fh_reg <= dogkp_pkg::RST_FRAME_HEIGHT;
            cl_reg <= dogkp_pkg::RST_CONTRAST_LIMIT;
            kl_reg <= dogkp_pkg::RST_CURVATURE_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dogkp_pkg::REG_FRAME_WIDTH:     fw_reg <= fw_clamp;
                dogkp_pkg::REG_FRAME_HEIGHT:    fh_reg <= fh_clamp;
                dogkp_pkg::REG_CONTRAST_LIMIT:  cl_reg <= cfg_data[dogkp_pkg::CONT_BITS-1:0];
                dogkp_pkg::REG_CURVATURE_LIMIT: kl_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR:  if (clr_reg == XB'(dogkp_pkg::MAX_WIDTH - 1)) state_next = ST_IDLE;
            ST_IDLE: if (accept) state_next = ST_WIN;
            ST_WIN:  state_next = ST_CALC;
            ST_CALC: state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUB;
            ST_SUB:  state_next = ST_FMUL;
            ST_FMUL: state_next = ST_OUT;
            ST_OUT:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_CLR;
        endcase
    end

    // Control state: sequencer, position counters, clear sweep, output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLR;
            col_reg       <= '0;
            line_reg      <= '0;
            clr_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CLR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (accept)
            begin
                col_reg  <= col_next;
                line_reg <= line_next;
            end
            if (state_reg == ST_OUT && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Item capture at acceptance.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            x_reg      <= x_cur;
            y_reg      <= y_cur;
            border_reg <= (x_cur >= XB'(2)) && (y_cur >= HB'(2));
            done_reg   <= ((WB+1)'(x_cur) == (WB+1)'(fw_reg) - 1'b1)
                       && ((HB+1)'(y_cur) == (HB+1)'(fh_reg) - 1'b1);
            s_reg      <= {pix_data.sample_above, pix_data.sample_mid,
                           pix_data.sample_below};
        end
    end

    // Result register load.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_OUT && out_free)
        begin
            res_reg.verdict    <= ev_verdict;
            res_reg.is_maximum <= ev_is_max;
            res_reg.centre_x   <= border_reg ? dogkp_pkg::CX_BITS'(x_reg - 1'b1) : '0;
            res_reg.centre_y   <= border_reg ? dogkp_pkg::CY_BITS'(y_reg - 1'b1) : '0;
            res_reg.frame_done <= done_reg;
        end
    end

    // Line store: entry holds the older line in the upper half.
    assign rd_line0 = ram_rdata[2*TB-1:TB];
    assign rd_line1 = ram_rdata[TB-1:0];

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = x_reg;
        ram_wdata = {rd_line1, s_reg};
        if (state_reg == ST_CLR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end
        else if (state_reg == ST_WIN)
        begin
            ram_we = 1'b1;
        end
    end

    dogkp_ram #(
        .DEPTH (dogkp_pkg::MAX_WIDTH),
        .WIDTH (2 * TB)
    ) u_line_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (x_cur),
        .rdata (ram_rdata)
    );

    // Step strobes for the evaluation datapath.
    always_comb
    begin
        ctl.shift     = (state_reg == ST_WIN);
        ctl.calc      = (state_reg == ST_CALC);
        ctl.mul       = (state_reg == ST_MUL);
        ctl.sub       = (state_reg == ST_SUB);
        ctl.fmul      = (state_reg == ST_FMUL);
        ctl.border_ok = border_reg;
    end

    dogkp_eval u_eval (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .col_line0       (rd_line0),
        .col_line1       (rd_line1),
        .col_new         (s_reg),
        .contrast_limit  (cl_reg),
        .curvature_limit (kl_reg),
        .verdict         (ev_verdict),
        .is_maximum      (ev_is_max)
    );

endmodule

// ===== rtl/core/dogkp_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// dogkp_checker
// Port-level checks of the detector, bound to the top level.
// ============================================================================
module dogkp_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 pix_valid,
    input logic                 pix_stall,
    input logic                 res_valid,
    input logic                 res_stall,
    input dogkp_pkg::out_item_t res_data
);

    // A stalled result item stays offered.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res_data))
        else $error("result item changed while stalled");

    // One item in flight: the input stalls right after an acceptance.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        pix_valid && !pix_stall |=> pix_stall)
        else $error("second item accepted while one is in work");

    // A tested candidate always names an interior centre.
    a_centre: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.verdict != dogkp_pkg::VERDICT_NONE
        |-> res_data.centre_x != '0 && res_data.centre_y != '0)
        else $error("candidate reported at a border position");

    // No candidate kind without a candidate.
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.verdict == dogkp_pkg::VERDICT_NONE
        |-> !res_data.is_maximum)
        else $error("maximum flag set without a candidate");

endmodule

bind dog_extremum_keypoint_detector dogkp_checker u_dogkp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_data  (res_data)
);
